FILE: rtl/core/kt_pkg.sv
// shared types and constants of the keyed table with random pick
package kt_pkg;

   localparam int DATA_W = 32;
   localparam int PICK_W = 16;
   localparam int FUNC_W = 2;
   localparam int STAT_W = 3;
   localparam int CAP_W  = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_PICK   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic key_we;
      logic val_we;
   } store_we_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_stat_type;

endpackage

FILE: rtl/core/kt_store.sv
// slot memory for keys and values, one write port and one registered read port
module kt_store #(
   parameter int ENTRIES = 16,
   parameter int IW      = 4
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [IW-1:0]             rd_addr,
   output logic [kt_pkg::DATA_W-1:0] rd_key,
   output logic [kt_pkg::DATA_W-1:0] rd_val,
   input  kt_pkg::store_we_type      we,
   input  logic [IW-1:0]             wr_addr,
   input  logic [kt_pkg::DATA_W-1:0] wr_key,
   input  logic [kt_pkg::DATA_W-1:0] wr_val
);

   logic [kt_pkg::DATA_W-1:0] key_mem_ff [ENTRIES];
   logic [kt_pkg::DATA_W-1:0] val_mem_ff [ENTRIES];
   logic [kt_pkg::DATA_W-1:0] rd_key_ff;
   logic [kt_pkg::DATA_W-1:0] rd_val_ff;

   always_ff @(posedge clock) begin
      if (we.key_we) begin
         key_mem_ff[wr_addr] <= wr_key;
      end
      if (we.val_we) begin
         val_mem_ff[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         rd_key_ff <= key_mem_ff[rd_addr];
         rd_val_ff <= val_mem_ff[rd_addr];
      end
   end

   assign rd_key = rd_key_ff;
   assign rd_val = rd_val_ff;

endmodule

FILE: rtl/core/kt_rem.sv
// bit-serial remainder unit: one restoring compare and subtract per cycle
module kt_rem #(
   parameter int CW = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [kt_pkg::PICK_W-1:0] dividend,
   input  logic [CW-1:0]             divisor,
   output kt_pkg::rem_stat_type      stat,
   output logic [CW-1:0]             rem
);

   localparam int SW = $clog2(kt_pkg::PICK_W + 1);
   localparam logic [SW-1:0] LAST_STEP = SW'(kt_pkg::PICK_W - 1);

   logic [kt_pkg::PICK_W-1:0] dividend_ff, dividend_in;
   logic [CW-1:0]             divisor_ff, divisor_in;
   logic [CW-1:0]             rem_ff, rem_in;
   logic [SW-1:0]             step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CW:0]               shifted;
   logic [CW:0]               diff;

   assign shifted = {rem_ff, dividend_ff[kt_pkg::PICK_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_comb begin
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      if (start) begin
         dividend_in = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
         step_in     = '0;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so the top bit drops
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in = diff[CW-1:0];
         end else begin
            rem_in = shifted[CW-1:0];
         end
         dividend_in = dividend_ff << 1;
         step_in     = step_ff + SW'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign rem       = rem_ff;

endmodule

FILE: rtl/core/keyed_table_with_random_pick_core.sv
// top level of the keyed table: request sequencer, slot scan and output register
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | func, key, value, rand_pick
//  rsp     | out       | rsp_valid / rsp_ready | status, value_out, key_out
//  csr     | in        | csr_valid / csr_ready | capacity limit (5 bits)
//
// add, remove and get scan the slots through the single read port, one slot a
// cycle; remove then reads the last slot and writes it into the hole.
// random pick runs the 16-step remainder unit and then one read.
// one request at a time: req_ready is high only while the sequencer is idle.
// a finished response waits in the output register while the next request is taken.
// synchronous active-high reset empties the table and sets the limit to 16.
module keyed_table_with_random_pick_core #(
   parameter int ENTRIES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic        [kt_pkg::FUNC_W-1:0] req_func,
   input  logic signed [kt_pkg::DATA_W-1:0] req_key,
   input  logic signed [kt_pkg::DATA_W-1:0] req_value,
   input  logic        [kt_pkg::PICK_W-1:0] req_rand_pick,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic        [kt_pkg::STAT_W-1:0] rsp_status,
   output logic signed [kt_pkg::DATA_W-1:0] rsp_value_out,
   output logic signed [kt_pkg::DATA_W-1:0] rsp_key_out,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic        [kt_pkg::CAP_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LW = (CW > kt_pkg::CAP_W) ? CW : kt_pkg::CAP_W;
   localparam logic [CW-1:0] COUNT_MAX = CW'(ENTRIES);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SCAN      = 3'd1;
   localparam logic [2:0] S_MOVE_RD   = 3'd2;
   localparam logic [2:0] S_MOVE_WR   = 3'd3;
   localparam logic [2:0] S_REM       = 3'd4;
   localparam logic [2:0] S_PICK_WAIT = 3'd5;
   localparam logic [2:0] S_RESP      = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [kt_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [kt_pkg::DATA_W-1:0] key_ff, key_in;
   logic [kt_pkg::DATA_W-1:0] value_ff, value_in;
   logic [kt_pkg::PICK_W-1:0] pick_ff, pick_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [kt_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [CW-1:0]             issue_ff, issue_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic [IW-1:0]             rd_idx_ff, rd_idx_in;
   logic [IW-1:0]             hit_idx_ff, hit_idx_in;
   logic [kt_pkg::STAT_W-1:0] res_status_ff, res_status_in;
   logic [kt_pkg::DATA_W-1:0] res_value_ff, res_value_in;
   logic [kt_pkg::DATA_W-1:0] res_key_ff, res_key_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [kt_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [kt_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [kt_pkg::DATA_W-1:0] rsp_key_ff, rsp_key_in;

   logic                      rd_en;
   logic [IW-1:0]             rd_addr;
   logic [kt_pkg::DATA_W-1:0] rd_key;
   logic [kt_pkg::DATA_W-1:0] rd_val;
   kt_pkg::store_we_type      we;
   logic [IW-1:0]             wr_addr;
   logic [kt_pkg::DATA_W-1:0] wr_key;
   logic [kt_pkg::DATA_W-1:0] wr_val;

   logic                      rem_start;
   kt_pkg::rem_stat_type      rem_stat;
   logic [CW-1:0]             rem;

   logic [CW-1:0]             count_m1;
   logic                      table_full;
   logic                      issue;
   logic                      hit;
   logic                      miss;
   logic                      load_rsp;

   kt_store #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_val  (rd_val),
      .we      (we),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_val  (wr_val)
   );

   kt_rem #(
      .CW (CW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (pick_ff),
      .divisor  (count_ff),
      .stat     (rem_stat),
      .rem      (rem)
   );

   assign count_m1   = count_ff - CW'(1);
   // effective limit is the smaller of the register and the storage
   assign table_full = (LW'(count_ff) >= LW'(cap_ff)) || (count_ff == COUNT_MAX);
   assign issue      = issue_ff < count_ff;
   assign hit        = rd_pend_ff && (rd_key == key_ff);
   assign miss       = (count_ff == '0) ||
                       (rd_pend_ff && !hit && (CW'(rd_idx_ff) == count_m1));
   assign load_rsp   = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      pick_in       = pick_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      rd_pend_in    = rd_pend_ff;
      rd_idx_in     = rd_idx_ff;
      hit_idx_in    = hit_idx_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_key_in    = res_key_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      we            = '0;
      wr_addr       = '0;
      wr_key        = '0;
      wr_val        = '0;
      rem_start     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               key_in        = req_key;
               value_in      = req_value;
               pick_in       = req_rand_pick;
               res_status_in = kt_pkg::ST_OK;
               res_value_in  = kt_pkg::ALL_ONES;
               res_key_in    = kt_pkg::ALL_ONES;
               issue_in      = '0;
               rd_pend_in    = 1'b0;
               if (req_func == kt_pkg::FUNC_PICK) begin
                  state_in = S_REM;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // read of the next slot overlaps the compare of the previous one
            rd_en      = issue;
            rd_addr    = issue_ff[IW-1:0];
            issue_in   = issue ? issue_ff + CW'(1) : issue_ff;
            rd_pend_in = issue;
            rd_idx_in  = issue_ff[IW-1:0];
            if (hit) begin
               unique case (func_ff)
                  kt_pkg::FUNC_ADD: begin
                     we.val_we     = 1'b1;
                     wr_addr       = rd_idx_ff;
                     wr_val        = value_ff;
                     res_status_in = kt_pkg::ST_UPDATED;
                     state_in      = S_RESP;
                  end
                  kt_pkg::FUNC_REMOVE: begin
                     hit_idx_in = rd_idx_ff;
                     state_in   = S_MOVE_RD;
                  end
                  kt_pkg::FUNC_GET: begin
                     res_value_in = rd_val;
                     state_in     = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end else if (miss) begin
               if (func_ff == kt_pkg::FUNC_ADD) begin
                  if (table_full) begin
                     res_status_in = kt_pkg::ST_FULL;
                  end else begin
                     we.key_we = 1'b1;
                     we.val_we = 1'b1;
                     wr_addr   = count_ff[IW-1:0];
                     wr_key    = key_ff;
                     wr_val    = value_ff;
                     count_in  = count_ff + CW'(1);
                  end
               end else begin
                  res_status_in = kt_pkg::ST_NOT_FOUND;
               end
               state_in = S_RESP;
            end
         end
         S_MOVE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = count_m1[IW-1:0];
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            // last slot fills the hole; harmless when the hole is the last slot
            we.key_we = 1'b1;
            we.val_we = 1'b1;
            wr_addr   = hit_idx_ff;
            wr_key    = rd_key;
            wr_val    = rd_val;
            count_in  = count_m1;
            state_in  = S_RESP;
         end
         S_REM: begin
            if (count_ff == '0) begin
               res_status_in = kt_pkg::ST_EMPTY;
               state_in      = S_RESP;
            end else if (rem_stat.done) begin
               rd_en    = 1'b1;
               rd_addr  = rem[IW-1:0];
               state_in = S_PICK_WAIT;
            end else if (!rem_stat.busy) begin
               rem_start = 1'b1;
            end
         end
         S_PICK_WAIT: begin
            res_key_in = rd_key;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cap_in        = cap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_key_in    = rsp_key_ff;
      if (csr_valid) begin
         cap_in = csr_wdata;
      end
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_value_in  = res_value_ff;
         rsp_key_in    = res_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= kt_pkg::CAP_RESET;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      pick_ff       <= pick_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      hit_idx_ff    <= hit_idx_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_key_ff    <= res_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_key_out   = rsp_key_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("entry count beyond storage");

   a_count_only_on_write : assert property (@(posedge clock) disable iff (reset)
      !(state_ff == S_SCAN || state_ff == S_MOVE_WR) |=> $stable(count_ff))
      else $error("entry count changed outside a table write");

   a_pick_after_rem : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PICK_WAIT) |-> ($past(rem_stat.done) && count_ff != '0))
      else $error("pick read without a finished remainder");

   a_rsp_not_overwritten : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !load_rsp)
      else $error("pending response overwritten");

endmodule
